/* design/assert_macros.svh */
// Assertion helpers shared by the modules of the difference histogram.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define XDBH_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define XDBH_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* design/xdbh_pkg.sv */
package xdbh_pkg;

	localparam int COUNT_BITS = 40;
	localparam int OUT_BITS   = 40;
	localparam int WORD_BITS  = 32;
	localparam int SEL_BITS   = $clog2(WORD_BITS);
	localparam int SCALE_BITS = 16;
	localparam int PROD_BITS  = COUNT_BITS + SCALE_BITS;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [WORD_BITS-1:0]  BLOCK_MASK_RST   = 32'h0000_0000;
	localparam logic [WORD_BITS-1:0]  SPECIAL_MASK_RST = 32'h7E00_0000;
	localparam logic [SCALE_BITS-1:0] RATE_SCALE_RST   = 16'd10000;

	typedef enum logic [1:0] {
		CMD_COMPARE = 2'd0,
		CMD_CLEAR   = 2'd1,
		CMD_QUERY   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_BLOCK_MASK   = 2'd0,
		REG_SPECIAL_MASK = 2'd1,
		REG_RATE_SCALE   = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic clear;
		logic inc;
	} cnt_ctl_t;

	typedef struct packed {
		logic clear;
		logic block_bump;
		logic rescale;
	} gate_ctl_t;

	// Counters are reported on 40-bit fields whatever their own width.
	function automatic logic [OUT_BITS-1:0] to_out(input logic [COUNT_BITS-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		return w[OUT_BITS-1:0];
	endfunction

endpackage

/* design/xor_diff_bit_histogram.sv */
// Channel  Handshake                    Fields
// item     item_valid / item_stall      cmd, first_word, reference_word, bit_index
// result   result_valid / result_stall  word_differs, five counts, bit_count, gate_fail
// cfg      cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One word per cycle unless result_stall or a rate_scale write holds it: an input
// register feeds the counter update, which loads the result register as it advances.
// Writing rate_scale holds item_stall high for one cycle while the scaled
// block product is rebuilt by the single multiplier.
// Reset clears all counters and loads the mask and scale defaults.
// A stalled result keeps the input register full; if that register is empty, one
// more word is taken before item_stall rises.
`include "assert_macros.svh"

module xor_diff_bit_histogram (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    cmd,
	input  logic [xdbh_pkg::WORD_BITS-1:0] first_word,
	input  logic [xdbh_pkg::WORD_BITS-1:0] reference_word,
	input  logic [xdbh_pkg::SEL_BITS-1:0] bit_index,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          word_differs,
	output logic [xdbh_pkg::OUT_BITS-1:0] compared_count,
	output logic [xdbh_pkg::OUT_BITS-1:0] mismatch_count,
	output logic [xdbh_pkg::OUT_BITS-1:0] block_mismatches,
	output logic [xdbh_pkg::OUT_BITS-1:0] special_mismatches,
	output logic [xdbh_pkg::OUT_BITS-1:0] other_mismatches,
	output logic [xdbh_pkg::OUT_BITS-1:0] bit_count,
	output logic                          gate_fail,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [xdbh_pkg::WORD_BITS-1:0] cfg_data
);

	localparam int CW = xdbh_pkg::COUNT_BITS;
	localparam int WW = xdbh_pkg::WORD_BITS;

	logic [WW-1:0]                     block_mask_q;
	logic [WW-1:0]                     special_mask_q;
	logic [xdbh_pkg::SCALE_BITS-1:0]   rate_scale_q;
	logic                              rescale_q;

	logic                              valid_s1;
	logic [1:0]                        cmd_s1;
	logic [WW-1:0]                     diff_s1;
	logic [xdbh_pkg::SEL_BITS-1:0]     sel_s1;

	logic adv;
	logic is_cmp;
	logic is_clr;
	logic differs;

	xdbh_pkg::cnt_ctl_t  cmp_ctl, mis_ctl, blk_ctl, spc_ctl, oth_ctl;
	xdbh_pkg::cnt_ctl_t  bit_ctl [WW];
	xdbh_pkg::gate_ctl_t gate_ctl;

	logic [CW-1:0] cmp_q, mis_q, blk_q, spc_q, oth_q;
	logic [CW-1:0] cmp_next, mis_next, blk_next, spc_next, oth_next;
	logic          blk_bump;
	logic [CW-1:0] bit_q    [WW];
	logic [CW-1:0] bit_next [WW];
	logic          fail_next;
	logic          cat_over;

	// Configuration is always taken; only the scale write stalls the item channel.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_mask_q   <= xdbh_pkg::BLOCK_MASK_RST;
			special_mask_q <= xdbh_pkg::SPECIAL_MASK_RST;
			rate_scale_q   <= xdbh_pkg::RATE_SCALE_RST;
			rescale_q      <= 1'b0;
		end else begin
			rescale_q <= cfg_valid && (cfg_index == xdbh_pkg::REG_RATE_SCALE);
			if (cfg_valid) begin
				case (cfg_index)
					xdbh_pkg::REG_BLOCK_MASK: begin
						block_mask_q <= cfg_data;
					end
					xdbh_pkg::REG_SPECIAL_MASK: begin
						special_mask_q <= cfg_data;
					end
					xdbh_pkg::REG_RATE_SCALE: begin
						rate_scale_q <= cfg_data[xdbh_pkg::SCALE_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign adv        = valid_s1 && (!result_valid || !result_stall);
	assign item_stall = rescale_q || (valid_s1 && !adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1  <= cmd;
			diff_s1 <= first_word ^ reference_word;
			sel_s1  <= bit_index;
		end
	end

	assign is_cmp  = (cmd_s1 == xdbh_pkg::CMD_COMPARE);
	assign is_clr  = (cmd_s1 == xdbh_pkg::CMD_CLEAR);
	assign differs = is_cmp && (diff_s1 != '0);

	always_comb begin
		cmp_ctl.clear = adv && is_clr;
		cmp_ctl.inc   = adv && is_cmp;
		mis_ctl.clear = adv && is_clr;
		mis_ctl.inc   = adv && differs;
		blk_ctl.clear = adv && is_clr;
		blk_ctl.inc   = adv && differs && ((diff_s1 & block_mask_q) != '0);
		spc_ctl.clear = adv && is_clr;
		spc_ctl.inc   = adv && differs && ((diff_s1 & special_mask_q) != '0);
		oth_ctl.clear = adv && is_clr;
		oth_ctl.inc   = adv && differs &&
			((diff_s1 & ~(block_mask_q | special_mask_q)) != '0);
		for (int i = 0; i < WW; i++) begin
			bit_ctl[i].clear = adv && is_clr;
			bit_ctl[i].inc   = adv && is_cmp && diff_s1[i];
		end
	end

	xdbh_sat_counter u_cmp (.clk(clk), .arst_n(arst_n), .ctl(cmp_ctl),
		.count_q(cmp_q), .count_next(cmp_next));
	xdbh_sat_counter u_mis (.clk(clk), .arst_n(arst_n), .ctl(mis_ctl),
		.count_q(mis_q), .count_next(mis_next));
	xdbh_sat_counter u_blk (.clk(clk), .arst_n(arst_n), .ctl(blk_ctl),
		.count_q(blk_q), .count_next(blk_next));
	xdbh_sat_counter u_spc (.clk(clk), .arst_n(arst_n), .ctl(spc_ctl),
		.count_q(spc_q), .count_next(spc_next));
	xdbh_sat_counter u_oth (.clk(clk), .arst_n(arst_n), .ctl(oth_ctl),
		.count_q(oth_q), .count_next(oth_next));

	for (genvar g = 0; g < WW; g++) begin : g_bit
		xdbh_sat_counter u_bit (.clk(clk), .arst_n(arst_n), .ctl(bit_ctl[g]),
			.count_q(bit_q[g]), .count_next(bit_next[g]));
	end

	// The product only moves when the block counter really moves, so it
	// stops growing once that counter has saturated.
	assign blk_bump = blk_ctl.inc && !blk_ctl.clear && (blk_q != xdbh_pkg::COUNT_MAX);

	always_comb begin
		gate_ctl.clear      = adv && is_clr;
		gate_ctl.block_bump = blk_bump;
		gate_ctl.rescale    = rescale_q;
	end

	xdbh_gate u_gate (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (gate_ctl),
		.scale        (rate_scale_q),
		.block_q      (blk_q),
		.compared_next(cmp_next),
		.other_next   (oth_next),
		.fail_next    (fail_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_differs       <= differs;
			compared_count     <= xdbh_pkg::to_out(cmp_next);
			mismatch_count     <= xdbh_pkg::to_out(mis_next);
			block_mismatches   <= xdbh_pkg::to_out(blk_next);
			special_mismatches <= xdbh_pkg::to_out(spc_next);
			other_mismatches   <= xdbh_pkg::to_out(oth_next);
			bit_count          <= xdbh_pkg::to_out(bit_next[sel_s1]);
			gate_fail          <= fail_next;
		end
	end

	assign cat_over = (blk_q > mis_q) || (spc_q > mis_q) || (oth_q > mis_q);

	`XDBH_ASSERT(a_mismatch_bounded, (mis_q <= cmp_q), "more mismatched than compared words")
	`XDBH_NEVER(a_category_bounded, cat_over, "category count above mismatch count")
	`XDBH_ASSERT(a_clear_empties,
		((adv && is_clr) |=> ((compared_count == '0) && (bit_count == '0))),
		"clear word left a nonzero count")
	`XDBH_ASSERT(a_differs_counted,
		((result_valid && word_differs) |-> (mismatch_count != '0)),
		"differing word reported with zero mismatches")
	for (genvar g = 0; g < WW; g++) begin : g_bit_chk
		`XDBH_ASSERT(a_bit_bounded, (bit_q[g] <= mis_q), "bit count above mismatch count")
	end

endmodule

/* design/xdbh_sat_counter.sv */
module xdbh_sat_counter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  xdbh_pkg::cnt_ctl_t              ctl,
	output logic [xdbh_pkg::COUNT_BITS-1:0] count_q,
	output logic [xdbh_pkg::COUNT_BITS-1:0] count_next
);

	logic bumped;

	assign bumped = !ctl.clear && ctl.inc && (count_q != xdbh_pkg::COUNT_MAX);

	always_comb begin
		if (ctl.clear) begin
			count_next = '0;
		end else if (bumped) begin
			count_next = count_q + xdbh_pkg::COUNT_BITS'(1);
		end else begin
			count_next = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

endmodule

/* design/xdbh_gate.sv */
`include "assert_macros.svh"

module xdbh_gate (
	input  logic                            clk,
	input  logic                            arst_n,
	input  xdbh_pkg::gate_ctl_t             ctl,
	input  logic [xdbh_pkg::SCALE_BITS-1:0] scale,
	input  logic [xdbh_pkg::COUNT_BITS-1:0] block_q,
	input  logic [xdbh_pkg::COUNT_BITS-1:0] compared_next,
	input  logic [xdbh_pkg::COUNT_BITS-1:0] other_next,
	output logic                            fail_next
);

	// prod_q tracks block count times rate scale, so the rate test is a plain
	// compare against the compared count instead of a division.
	logic [xdbh_pkg::PROD_BITS-1:0] prod_q;
	logic [xdbh_pkg::PROD_BITS-1:0] prod_next;

	always_comb begin
		if (ctl.clear) begin
			prod_next = '0;
		end else if (ctl.block_bump) begin
			prod_next = prod_q + xdbh_pkg::PROD_BITS'(scale);
		end else begin
			prod_next = prod_q;
		end
	end

	assign fail_next = (compared_next == '0) || (other_next != '0) ||
		(prod_next > xdbh_pkg::PROD_BITS'(compared_next));

	// A new rate scale rebuilds the product from the block count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
		end else if (ctl.rescale) begin
			prod_q <= xdbh_pkg::PROD_BITS'(block_q) * xdbh_pkg::PROD_BITS'(scale);
		end else begin
			prod_q <= prod_next;
		end
	end

	`XDBH_ASSERT(a_prod_zero_without_block, ((block_q == '0) |-> (prod_q == '0)), "scaled block product nonzero with no block mismatches")

endmodule

/* sim/xdbh_checker.sv */
`timescale 1ns / 1ps

// Watches the item, result and configuration channels of the difference
// histogram. It keeps its own tallies and expected result words.
module xdbh_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic                           item_stall,
	input  logic [1:0]                     cmd,
	input  logic [xdbh_pkg::WORD_BITS-1:0] first_word,
	input  logic [xdbh_pkg::WORD_BITS-1:0] reference_word,
	input  logic [xdbh_pkg::SEL_BITS-1:0]  bit_index,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  logic                           word_differs,
	input  logic [xdbh_pkg::OUT_BITS-1:0]  compared_count,
	input  logic [xdbh_pkg::OUT_BITS-1:0]  mismatch_count,
	input  logic [xdbh_pkg::OUT_BITS-1:0]  block_mismatches,
	input  logic [xdbh_pkg::OUT_BITS-1:0]  special_mismatches,
	input  logic [xdbh_pkg::OUT_BITS-1:0]  other_mismatches,
	input  logic [xdbh_pkg::OUT_BITS-1:0]  bit_count,
	input  logic                           gate_fail,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [xdbh_pkg::WORD_BITS-1:0] cfg_data,
	output int                             errors,
	output int                             pending
);
	import xdbh_pkg::*;

	typedef struct packed {
		logic                differs;
		logic [OUT_BITS-1:0] compared;
		logic [OUT_BITS-1:0] mismatched;
		logic [OUT_BITS-1:0] blocks;
		logic [OUT_BITS-1:0] specials;
		logic [OUT_BITS-1:0] others;
		logic [OUT_BITS-1:0] bit_tally;
		logic                fails;
	} tally_word_t;

	logic [WORD_BITS-1:0]  block_mask;
	logic [WORD_BITS-1:0]  special_mask;
	logic [SCALE_BITS-1:0] rate_scale;

	logic [COUNT_BITS-1:0] compared_tally;
	logic [COUNT_BITS-1:0] mismatch_tally;
	logic [COUNT_BITS-1:0] block_tally;
	logic [COUNT_BITS-1:0] special_tally;
	logic [COUNT_BITS-1:0] other_tally;
	logic [COUNT_BITS-1:0] per_bit_tally [WORD_BITS];

	tally_word_t expected_tallies [$];

	function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
		return (v == COUNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic void clear_tallies();
		compared_tally = '0;
		mismatch_tally = '0;
		block_tally    = '0;
		special_tally  = '0;
		other_tally    = '0;
		for (int i = 0; i < WORD_BITS; i++)
			per_bit_tally[i] = '0;
	endfunction

	// A zero scale never fails the block test. The division form keeps
	// the comparison exact without a wide product.
	function automatic logic gate_fails();
		if (compared_tally == '0 || other_tally != '0)
			return 1'b1;
		if (rate_scale != '0 && block_tally > compared_tally / rate_scale)
			return 1'b1;
		return 1'b0;
	endfunction

	function automatic tally_word_t apply_word(input logic [1:0] op,
			input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] b,
			input logic [SEL_BITS-1:0] sel);
		tally_word_t          w;
		logic [WORD_BITS-1:0] x;
		x = a ^ b;
		w.differs = 1'b0;
		if (op == CMD_COMPARE) begin
			compared_tally = bump(compared_tally);
			if (x != '0) begin
				w.differs = 1'b1;
				mismatch_tally = bump(mismatch_tally);
				if ((x & block_mask) != '0)
					block_tally = bump(block_tally);
				if ((x & special_mask) != '0)
					special_tally = bump(special_tally);
				if ((x & ~(block_mask | special_mask)) != '0)
					other_tally = bump(other_tally);
				for (int i = 0; i < WORD_BITS; i++)
					if (x[i])
						per_bit_tally[i] = bump(per_bit_tally[i]);
			end
		end else if (op == CMD_CLEAR) begin
			clear_tallies();
		end
		w.compared   = compared_tally;
		w.mismatched = mismatch_tally;
		w.blocks     = block_tally;
		w.specials   = special_tally;
		w.others     = other_tally;
		w.bit_tally  = per_bit_tally[sel];
		w.fails      = gate_fails();
		return w;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
		end
	endtask

	task automatic check_result();
		tally_word_t w;
		if (expected_tallies.size() == 0) begin
			errors++;
			$error("result word with no expectation pending");
		end else begin
			w = expected_tallies.pop_front();
			check_field("word_differs", 64'(w.differs), 64'(word_differs));
			check_field("compared_count", 64'(w.compared), 64'(compared_count));
			check_field("mismatch_count", 64'(w.mismatched), 64'(mismatch_count));
			check_field("block_mismatches", 64'(w.blocks), 64'(block_mismatches));
			check_field("special_mismatches", 64'(w.specials),
				64'(special_mismatches));
			check_field("other_mismatches", 64'(w.others), 64'(other_mismatches));
			check_field("bit_count", 64'(w.bit_tally), 64'(bit_count));
			check_field("gate_fail", 64'(w.fails), 64'(gate_fail));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_mask   = BLOCK_MASK_RST;
			special_mask = SPECIAL_MASK_RST;
			rate_scale   = RATE_SCALE_RST;
			clear_tallies();
			expected_tallies.delete();
			errors  = 0;
			pending = 0;
		end else begin
			// A result leaving now was computed from an earlier word.
			if (result_valid && !result_stall)
				check_result();
			if (item_valid && !item_stall)
				expected_tallies.insert(expected_tallies.size(),
					apply_word(cmd, first_word, reference_word, bit_index));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BLOCK_MASK:   block_mask = cfg_data;
					REG_SPECIAL_MASK: special_mask = cfg_data;
					REG_RATE_SCALE:   rate_scale = cfg_data[SCALE_BITS-1:0];
					default: ;
				endcase
			end
			pending = expected_tallies.size();
		end
	end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import xdbh_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_LIMIT  = 4000;
	localparam int HOLD_CYCLES = 250;
	localparam int SETTLE      = 8;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 160;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	logic [1:0]            cmd;
	logic [WORD_BITS-1:0]  first_word;
	logic [WORD_BITS-1:0]  reference_word;
	logic [SEL_BITS-1:0]   bit_index;
	logic                  result_valid;
	logic                  result_stall;
	logic                  word_differs;
	logic [OUT_BITS-1:0]   compared_count;
	logic [OUT_BITS-1:0]   mismatch_count;
	logic [OUT_BITS-1:0]   block_mismatches;
	logic [OUT_BITS-1:0]   special_mismatches;
	logic [OUT_BITS-1:0]   other_mismatches;
	logic [OUT_BITS-1:0]   bit_count;
	logic                  gate_fail;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [1:0]            cfg_index;
	logic [WORD_BITS-1:0]  cfg_data;
	int                    errors;
	int                    pending;

	// Masks as last written, used only to aim the random differences.
	logic [WORD_BITS-1:0]  cur_block;
	logic [WORD_BITS-1:0]  cur_special;
	bit                    send_quiet;
	bit                    stall_quiet;
	bit                    hold_req;
	int                    idle_cycles;

	xor_diff_bit_histogram DUT (.*);
	xdbh_checker checker_i (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic offer(input logic [1:0] op, input logic [WORD_BITS-1:0] a,
			input logic [WORD_BITS-1:0] b, input logic [SEL_BITS-1:0] sel,
			input int gap);
		@(negedge clk);
		item_valid     <= 1'b1;
		cmd            <= op;
		first_word     <= a;
		reference_word <= b;
		bit_index      <= sel;
		do @(posedge clk); while (item_stall);
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Waits until every expected result word has come back.
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [WORD_BITS-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_BLOCK_MASK)
			cur_block = d;
		else if (idx == REG_SPECIAL_MASK)
			cur_special = d;
	endtask

	function automatic logic [WORD_BITS-1:0] pick_mask();
		int lo;
		int r;
		r = $urandom_range(0, 5);
		lo = $urandom_range(0, 31);
		case (r)
			0: return '0;
			1: return '1;
			2: return ({WORD_BITS{1'b1}} << lo) & ~({WORD_BITS{1'b1}} << $urandom_range(lo, 31));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [WORD_BITS-1:0] pick_scale();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 32'h0000_0001;
			1: return 32'h0000_FFFF;
			2: return 32'h0000_0000;
			3, 4, 5: return $urandom_range(1, 8);
			default: return $urandom_range(1, 65535);
		endcase
	endfunction

	task automatic random_word(input int gap);
		logic [1:0]           op;
		logic [WORD_BITS-1:0] b;
		logic [WORD_BITS-1:0] diff;
		int                   r;
		r = $urandom_range(0, 99);
		if (r < 78)
			op = CMD_COMPARE;
		else if (r < 88)
			op = CMD_QUERY;
		else if (r < 96)
			op = CMD_UNUSED;
		else
			op = CMD_CLEAR;
		case ($urandom_range(0, 3))
			0: b = '0;
			1: b = '1;
			default: b = $urandom;
		endcase
		case ($urandom_range(0, 9))
			0, 1: diff = '0;
			2: diff = 32'h1 << $urandom_range(0, 31);
			3, 4: diff = $urandom & cur_block;
			5, 6: diff = $urandom & cur_special;
			7: diff = $urandom & $urandom;
			8: diff = $urandom;
			default: diff = '1;
		endcase
		offer(op, b ^ diff, b, SEL_BITS'($urandom_range(0, 31)), gap);
	endtask

	// Receiver side: random stalls, or one long hold-off on request.
	initial begin
		bit hold_done;
		hold_done    = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				result_stall <= 1'b0;
			end else if (stall_quiet || $urandom_range(0, 3) != 0) begin
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b1;
				repeat (pick_gap(1'b0)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		cmd            = CMD_QUERY;
		first_word     = '0;
		reference_word = '0;
		bit_index      = '0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_BLOCK_MASK;
		cfg_data       = '0;
		cur_block      = BLOCK_MASK_RST;
		cur_special    = SPECIAL_MASK_RST;
		send_quiet     = 1'b0;
		stall_quiet    = 1'b0;
		hold_req       = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default masks: nothing compared yet, then special and other bits.
		offer(CMD_QUERY, 32'h0, 32'h0, 5'd0, 0);
		offer(CMD_UNUSED, 32'hFFFF_FFFF, 32'h0, 5'd31, 1);
		offer(CMD_COMPARE, 32'h0, 32'h0, 5'd0, 0);
		offer(CMD_COMPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 0);
		offer(CMD_COMPARE, 32'h0200_0000, 32'h0, 5'd25, 2);
		offer(CMD_COMPARE, 32'hFFFF_FFFF, 32'h0, 5'd0, 0);
		offer(CMD_QUERY, 32'h0, 32'h0, 5'd31, 0);
		offer(CMD_CLEAR, 32'h0, 32'h0, 5'd5, 0);
		offer(CMD_COMPARE, 32'h8000_0000, 32'h0, 5'd31, 0);
		drain();

		// Every bit in the block category with the strictest rate.
		write_reg(REG_BLOCK_MASK, 32'hFFFF_FFFF);
		write_reg(REG_SPECIAL_MASK, 32'h0);
		write_reg(REG_RATE_SCALE, 32'h0000_FFFF);
		offer(CMD_CLEAR, 32'h0, 32'h0, 5'd0, 0);
		offer(CMD_COMPARE, 32'h0, 32'h1, 5'd0, 0);
		offer(CMD_COMPARE, 32'h1234_5678, 32'h1234_5678, 5'd3, 0);
		drain();

		// Overlapping masks: a bit in both counts toward both categories.
		write_reg(REG_BLOCK_MASK, 32'h0000_FFFF);
		write_reg(REG_SPECIAL_MASK, 32'h00FF_FF00);
		write_reg(REG_RATE_SCALE, 32'h1);
		offer(CMD_COMPARE, 32'h0000_0F00, 32'h0, 5'd8, 0);
		offer(CMD_COMPARE, 32'h00FF_0000, 32'h0, 5'd16, 0);
		offer(CMD_COMPARE, 32'h0000_000F, 32'h0, 5'd3, 0);
		drain();

		// A zero scale never fails the block test.
		write_reg(REG_RATE_SCALE, 32'h0);
		offer(CMD_COMPARE, 32'h0000_00FF, 32'h0, 5'd7, 0);
		offer(CMD_QUERY, 32'h0, 32'h0, 5'd0, 0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_BLOCK_MASK, pick_mask());
			write_reg(REG_SPECIAL_MASK, pick_mask());
			write_reg(REG_RATE_SCALE, pick_scale());
			stall_quiet = ($urandom_range(0, 3) == 0);
			if (p == 2) begin
				// Keep offering words while results are held back.
				hold_req = 1'b1;
				repeat (40) random_word(0);
			end
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 40 == 0)
					send_quiet = ($urandom_range(0, 2) == 0);
				random_word(pick_gap(send_quiet));
			end
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
